// File: rtl/ers_pkg.sv
`timescale 1ns / 1ps

package ers_pkg;

	localparam int MAX_PERIOD    = 255;
	localparam int SAMPLE_BITS   = 32;
	localparam int FRACTION_BITS = 16;

	localparam int CFG_W      = 8;
	localparam int ADDR_W     = $clog2(MAX_PERIOD + 1);
	localparam int RING_DEPTH = 1 << ADDR_W;
	localparam int PERIOD_W   = ADDR_W;
	localparam int SUM_W      = SAMPLE_BITS + ADDR_W + 1;
	localparam int RATIO_W    = FRACTION_BITS + 1;
	localparam int CNT_W      = $clog2(FRACTION_BITS + 1);

	localparam logic [CFG_W-1:0] PERIOD_RESET = CFG_W'(10);
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_SIGN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
	localparam logic [RATIO_W-1:0] RATIO_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

	typedef struct packed {
		logic capture;
		logic update;
		logic rd_next;
		logic rd_oldest;
		logic calc;
		logic div_init;
		logic div_step;
		logic load_out;
	} ers_cmd_t;

	typedef struct packed {
		logic window_full;
		logic div_trivial;
		logic div_last;
	} ers_sts_t;

	// A period of zero acts as one; anything above MAX_PERIOD is clamped to it.
	function automatic logic [PERIOD_W-1:0] eff_period(input logic [CFG_W-1:0] per);
		if (per == '0) return PERIOD_W'(1);
		if (int'(per) > MAX_PERIOD) return PERIOD_W'(MAX_PERIOD);
		return PERIOD_W'(per);
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] abs_diff(input logic [SAMPLE_BITS-1:0] a,
			input logic [SAMPLE_BITS-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

endpackage

// File: rtl/efficiency_ratio_stream.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// sample    in         in_valid / in_ready    sample[31:0], signed price
// ratio     out        out_valid / out_ready  ratio[16:0], unsigned, 16 fraction bits
// config    in         cfg_we, no wait        cfg_wdata[7:0], period
//
// A sample that only fills the window goes back to idle after its update; one that
// gives a result also runs the ring read sequence and the restoring divider,
// which retires one quotient bit per cycle. A zero net change or path sum, or a
// net change at least the path sum, skips the divider and gives zero or 1.0.
// Reset clears the fill count, path sum and ring head and sets the period to 10.
// A finished result sits in the output register; the next request is taken while
// it waits, and the block stalls only if a second result is ready before then.

module efficiency_ratio_stream (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ers_pkg::CFG_W-1:0]             cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [ers_pkg::SAMPLE_BITS-1:0]       sample,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [ers_pkg::RATIO_W-1:0]           ratio
);

	ers_pkg::ers_cmd_t cmd;
	ers_pkg::ers_sts_t sts;

	ers_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ers_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sample    (sample),
		.cmd       (cmd),
		.sts       (sts),
		.ratio     (ratio)
	);

endmodule

// File: rtl/ers_ctrl.sv
`timescale 1ns / 1ps

module ers_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  ers_pkg::ers_sts_t   sts,
	output ers_pkg::ers_cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPD,
		S_RD_A,
		S_RD_B,
		S_CALC,
		S_DINIT,
		S_DIV,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   load;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	// The result register is free when it is empty or its current result is being taken.
	assign load      = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		cmd           = '0;
		cmd.capture   = (state_q == S_IDLE) && in_valid;
		cmd.update    = (state_q == S_UPD);
		cmd.rd_next   = (state_q == S_RD_A);
		cmd.rd_oldest = (state_q == S_RD_B);
		cmd.calc      = (state_q == S_CALC);
		cmd.div_init  = (state_q == S_DINIT);
		cmd.div_step  = (state_q == S_DIV);
		cmd.load_out  = load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_UPD;
				end
				S_UPD: begin
					state_q <= sts.window_full ? S_RD_A : S_IDLE;
				end
				S_RD_A:  state_q <= S_RD_B;
				S_RD_B:  state_q <= S_CALC;
				S_CALC:  state_q <= S_DINIT;
				S_DINIT: begin
					state_q <= sts.div_trivial ? S_FIN : S_DIV;
				end
				S_DIV: begin
					if (sts.div_last) state_q <= S_FIN;
				end
				S_FIN: begin
					if (load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/ers_datapath.sv
`timescale 1ns / 1ps

module ers_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ers_pkg::CFG_W-1:0]             cfg_wdata,
	input  logic [ers_pkg::SAMPLE_BITS-1:0]       sample,
	input  ers_pkg::ers_cmd_t                     cmd,
	output ers_pkg::ers_sts_t                     sts,
	output logic [ers_pkg::RATIO_W-1:0]           ratio
);

	logic [ers_pkg::SAMPLE_BITS-1:0] ring_q [ers_pkg::RING_DEPTH];
	logic [ers_pkg::SAMPLE_BITS-1:0] rd_data_q;
	logic [ers_pkg::ADDR_W-1:0]      head_q;
	logic [ers_pkg::ADDR_W-1:0]      rd_addr_q;

	logic [ers_pkg::CFG_W-1:0]       period_q;
	logic [ers_pkg::PERIOD_W-1:0]    fill_q;
	logic [ers_pkg::PERIOD_W-1:0]    eff_p;

	logic [ers_pkg::SAMPLE_BITS-1:0] x_in;
	logic [ers_pkg::SAMPLE_BITS-1:0] x_q;
	logic [ers_pkg::SAMPLE_BITS-1:0] prev_q;
	logic [ers_pkg::SAMPLE_BITS-1:0] diff_q;
	logic [ers_pkg::SAMPLE_BITS-1:0] oldest_q;
	logic [ers_pkg::SAMPLE_BITS-1:0] net_q;
	logic [ers_pkg::SAMPLE_BITS-1:0] drop_q;

	logic [ers_pkg::SUM_W-1:0]       sum_q;
	logic [ers_pkg::SUM_W-1:0]       den_q;
	logic [ers_pkg::SUM_W-1:0]       rem_q;
	logic [ers_pkg::SUM_W:0]         rem_sh;
	logic [ers_pkg::SUM_W:0]         rem_sub;
	logic                            rem_ge;
	logic [ers_pkg::SUM_W-1:0]       net_ext;
	logic [ers_pkg::SUM_W-1:0]       drop_ext;
	logic [ers_pkg::SUM_W-1:0]       diff_ext;
	logic                            saturate;
	logic [ers_pkg::RATIO_W-1:0]     quo_q;
	logic [ers_pkg::CNT_W-1:0]       cnt_q;
	logic [ers_pkg::RATIO_W-1:0]     ratio_q;

	// Flipping the sign bit makes unsigned order match signed order.
	assign x_in     = sample ^ ers_pkg::SAMPLE_SIGN;
	assign eff_p    = ers_pkg::eff_period(period_q);

	assign net_ext  = {{(ers_pkg::SUM_W - ers_pkg::SAMPLE_BITS){1'b0}}, net_q};
	assign drop_ext = {{(ers_pkg::SUM_W - ers_pkg::SAMPLE_BITS){1'b0}}, drop_q};
	assign diff_ext = {{(ers_pkg::SUM_W - ers_pkg::SAMPLE_BITS){1'b0}}, diff_q};

	assign rem_sh   = {rem_q, 1'b0};
	assign rem_ge   = (rem_sh >= {1'b0, den_q});
	assign rem_sub  = rem_sh - {1'b0, den_q};

	assign saturate = (net_q != '0) && (sum_q != '0) && (net_ext >= sum_q);

	assign sts.window_full = (fill_q >= eff_p);
	assign sts.div_trivial = (net_q == '0) || (sum_q == '0) || (net_ext >= sum_q);
	assign sts.div_last    = (cnt_q == ers_pkg::CNT_W'(1));

	assign ratio = ratio_q;

	// Sample ring: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.update) ring_q[head_q] <= x_q;
		rd_data_q <= ring_q[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= ers_pkg::PERIOD_RESET;
			fill_q   <= '0;
			sum_q    <= '0;
			head_q   <= '0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
				fill_q   <= '0;
				sum_q    <= '0;
			end else if (cmd.update) begin
				if (fill_q != '0) sum_q <= sum_q + diff_ext;
				if (fill_q < eff_p) fill_q <= fill_q + ers_pkg::PERIOD_W'(1);
				head_q <= head_q + ers_pkg::ADDR_W'(1);
			end else if (cmd.div_init) begin
				sum_q <= (sum_q >= drop_ext) ? (sum_q - drop_ext) : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q    <= x_in;
			diff_q <= ers_pkg::abs_diff(x_in, prev_q);
		end
		if (cmd.update) begin
			prev_q    <= x_q;
			rd_addr_q <= head_q - ers_pkg::ADDR_W'(eff_p);
		end
		if (cmd.rd_next) rd_addr_q <= rd_addr_q + ers_pkg::ADDR_W'(1);
		if (cmd.rd_oldest) oldest_q <= rd_data_q;
		if (cmd.calc) begin
			net_q  <= ers_pkg::abs_diff(x_q, oldest_q);
			drop_q <= ers_pkg::abs_diff(rd_data_q, oldest_q);
		end
		if (cmd.div_init) begin
			den_q <= sum_q;
			rem_q <= net_ext;
			cnt_q <= ers_pkg::CNT_W'(ers_pkg::FRACTION_BITS);
			quo_q <= saturate ? ers_pkg::RATIO_ONE : '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sub[ers_pkg::SUM_W-1:0] : rem_sh[ers_pkg::SUM_W-1:0];
			quo_q <= {quo_q[ers_pkg::RATIO_W-2:0], rem_ge};
			cnt_q <= cnt_q - ers_pkg::CNT_W'(1);
		end
		if (cmd.load_out) ratio_q <= quo_q;
	end

endmodule
